// ===== sv/cvwg_pkg.sv =====
package cvwg_pkg;

	localparam int LANES_DEF       = 8;
	localparam int LENGTH_BITS_DEF = 17;

	// 1024 LSB per volt, 0..10 V
	localparam int FULL_SCALE     = 10240;
	localparam int DEFAULT_LENGTH = 960;
	localparam int VAL_W          = 14;
	localparam int CV_W           = 16;
	localparam int GAIN_W         = 16;
	localparam int OFS_W          = 15;
	localparam int LVL_W          = 16;
	localparam int PROD_W         = CV_W + GAIN_W;
	localparam int Q_SHIFT        = 13;
	localparam int MASK_W         = 8;
	localparam int LANE_IDX_W     = 3;
	localparam int CFG_IDX_W      = 3;
	localparam int CFG_DATA_W     = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_GAIN     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_OFFSET   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CLOCKED  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_CLK_HIGH = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_CLK_LOW  = 3'd4;

	localparam logic signed [GAIN_W-1:0] GAIN_RST     = 16'sd8192;
	localparam logic signed [OFS_W-1:0]  OFFSET_RST   = 15'sd0;
	localparam logic signed [LVL_W-1:0]  CLK_HIGH_RST = 16'sd1024;
	localparam logic signed [LVL_W-1:0]  CLK_LOW_RST  = 16'sd0;

	localparam logic OP_TICK  = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	// control that travels with an item from stage 1 to stage 2
	typedef struct packed {
		logic                  valid;
		logic                  wr;
		logic [LANE_IDX_W-1:0] lane;
	} s2_ctl_t;

endpackage

// ===== sv/cvwg_if.sv =====
interface cvwg_in_if #(
	parameter int LENGTH_BITS = cvwg_pkg::LENGTH_BITS_DEF
);
	logic                                 valid;
	logic                                 ready;
	logic                                 opcode;
	logic signed [cvwg_pkg::CV_W-1:0]     cv_sample;
	logic signed [cvwg_pkg::LVL_W-1:0]    clock_level;
	logic [cvwg_pkg::LANE_IDX_W-1:0]      lane_index;
	logic [LENGTH_BITS-1:0]               length_ticks;

	modport source(output valid, opcode, cv_sample, clock_level, lane_index, length_ticks,
		input ready);
	modport sink(input valid, opcode, cv_sample, clock_level, lane_index, length_ticks,
		output ready);
endinterface

interface cvwg_out_if;
	logic                          valid;
	logic                          ready;
	logic [cvwg_pkg::MASK_W-1:0]   pulse_mask;
	logic [cvwg_pkg::MASK_W-1:0]   window_mask;

	modport source(output valid, pulse_mask, window_mask, input ready);
	modport sink(input valid, pulse_mask, window_mask, output ready);
endinterface

// ===== sv/cvwg_lane_mem.sv =====
module cvwg_lane_mem #(
	parameter int LANES       = cvwg_pkg::LANES_DEF,
	parameter int LENGTH_BITS = cvwg_pkg::LENGTH_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         rem_we,
	input  logic [LANES*LENGTH_BITS-1:0] rem_wd,
	input  logic [LANES-1:0]             len_we,
	input  logic [LENGTH_BITS-1:0]       len_wd,
	output logic [LANES*LENGTH_BITS-1:0] rem_rd,
	output logic [LANES*LENGTH_BITS-1:0] len_rd
);

	localparam int ROW_W = LANES * LENGTH_BITS;

	// one row per store, lane fields side by side, per-lane write enables on lengths
	logic [ROW_W-1:0] rem_mem [1];
	logic [ROW_W-1:0] len_mem [1];

	logic [ROW_W-1:0]       rem_rd_q;
	logic [ROW_W-1:0]       len_rd_q;
	logic [ROW_W-1:0]       rem_wd_q;
	logic [LENGTH_BITS-1:0] len_wd_q;
	logic                   rem_we_q;
	logic [LANES-1:0]       len_we_q;
	logic                   rem_ok_q;
	logic [LANES-1:0]       len_ok_q;

	always_ff @(posedge clk) begin
		if (rem_we) begin
			rem_mem[0] <= rem_wd;
		end
		for (int i = 0; i < LANES; i++) begin
			if (len_we[i]) begin
				len_mem[0][i*LENGTH_BITS +: LENGTH_BITS] <= len_wd;
			end
		end
		rem_rd_q <= rem_mem[0];
		len_rd_q <= len_mem[0];
		rem_wd_q <= rem_wd;
		len_wd_q <= len_wd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_we_q <= 1'b0;
			len_we_q <= '0;
			rem_ok_q <= 1'b0;
			len_ok_q <= '0;
		end else begin
			rem_we_q <= rem_we;
			len_we_q <= len_we;
			rem_ok_q <= rem_ok_q | rem_we;
			len_ok_q <= len_ok_q | len_we;
		end
	end

	// registered read data misses a same-edge write: forward the write
	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			if (rem_we_q) begin
				rem_rd[i*LENGTH_BITS +: LENGTH_BITS] = rem_wd_q[i*LENGTH_BITS +: LENGTH_BITS];
			end else if (rem_ok_q) begin
				rem_rd[i*LENGTH_BITS +: LENGTH_BITS] = rem_rd_q[i*LENGTH_BITS +: LENGTH_BITS];
			end else begin
				rem_rd[i*LENGTH_BITS +: LENGTH_BITS] = '0;
			end

			if (len_we_q[i]) begin
				len_rd[i*LENGTH_BITS +: LENGTH_BITS] = len_wd_q;
			end else if (len_ok_q[i]) begin
				len_rd[i*LENGTH_BITS +: LENGTH_BITS] = len_rd_q[i*LENGTH_BITS +: LENGTH_BITS];
			end else begin
				len_rd[i*LENGTH_BITS +: LENGTH_BITS] = LENGTH_BITS'(cvwg_pkg::DEFAULT_LENGTH);
			end
		end
	end

endmodule

// ===== sv/cvwg_front.sv =====
module cvwg_front #(
	parameter int LANES       = cvwg_pkg::LANES_DEF,
	parameter int LENGTH_BITS = cvwg_pkg::LENGTH_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [cvwg_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [cvwg_pkg::CFG_DATA_W-1:0]       cfg_data,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic                                  opcode,
	input  logic signed [cvwg_pkg::CV_W-1:0]      cv_sample,
	input  logic signed [cvwg_pkg::LVL_W-1:0]     clock_level,
	input  logic [cvwg_pkg::LANE_IDX_W-1:0]       lane_index,
	input  logic [LENGTH_BITS-1:0]                length_ticks,
	input  logic                                  s2_free,
	output logic                                  s1_go,
	output cvwg_pkg::s2_ctl_t                     ctl_s1,
	output logic [LENGTH_BITS-1:0]                len_s1,
	output logic [LANES-1:0]                      win_s1
);

	localparam int WIN_W = $clog2((LANES + 1) * cvwg_pkg::FULL_SCALE) + 1;
	localparam int SUM_W = cvwg_pkg::PROD_W - cvwg_pkg::Q_SHIFT + 1;

	logic signed [cvwg_pkg::GAIN_W-1:0] gain_q;
	logic signed [cvwg_pkg::OFS_W-1:0]  offset_q;
	logic                               clocked_q;
	logic signed [cvwg_pkg::LVL_W-1:0]  clk_high_q;
	logic signed [cvwg_pkg::LVL_W-1:0]  clk_low_q;

	logic                                 schmitt_q;
	logic [cvwg_pkg::VAL_W-1:0]           held_q;

	logic                                 v_s1;
	logic                                 op_s1;
	logic signed [cvwg_pkg::PROD_W-1:0]   prod_s1;
	logic signed [cvwg_pkg::LVL_W-1:0]    clk_s1;
	logic [cvwg_pkg::LANE_IDX_W-1:0]      lane_s1;
	logic [LENGTH_BITS-1:0]               length_s1;

	logic                                 accept;
	logic signed [cvwg_pkg::PROD_W-1:0]   product;
	logic signed [SUM_W-2:0]              floor_g;
	logic signed [SUM_W-1:0]              live_raw;
	logic [cvwg_pkg::VAL_W-1:0]           live;
	logic                                 clk_rise;
	logic                                 clk_fall;
	logic                                 tick_go;
	logic [cvwg_pkg::VAL_W-1:0]           val;
	logic [WIN_W-1:0]                     scaled;

	assign accept   = in_valid && in_ready;
	assign s1_go    = v_s1 && s2_free;
	assign in_ready = !v_s1 || s1_go;
	assign product  = cv_sample * gain_q;
	assign tick_go  = s1_go && (op_s1 == cvwg_pkg::OP_TICK);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q     <= cvwg_pkg::GAIN_RST;
			offset_q   <= cvwg_pkg::OFFSET_RST;
			clocked_q  <= 1'b0;
			clk_high_q <= cvwg_pkg::CLK_HIGH_RST;
			clk_low_q  <= cvwg_pkg::CLK_LOW_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				cvwg_pkg::CFG_GAIN:     gain_q     <= cfg_data[cvwg_pkg::GAIN_W-1:0];
				cvwg_pkg::CFG_OFFSET:   offset_q   <= cfg_data[cvwg_pkg::OFS_W-1:0];
				cvwg_pkg::CFG_CLOCKED:  clocked_q  <= cfg_data[0];
				cvwg_pkg::CFG_CLK_HIGH: clk_high_q <= cfg_data[cvwg_pkg::LVL_W-1:0];
				cvwg_pkg::CFG_CLK_LOW:  clk_low_q  <= cfg_data[cvwg_pkg::LVL_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			schmitt_q <= 1'b0;
			held_q    <= '0;
		end else begin
			if (accept) begin
				v_s1 <= 1'b1;
			end else if (s1_go) begin
				v_s1 <= 1'b0;
			end
			if (tick_go) begin
				if (clk_rise) begin
					schmitt_q <= 1'b1;
					held_q    <= live;
				end else if (clk_fall) begin
					schmitt_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1     <= opcode;
			prod_s1   <= product;
			clk_s1    <= clock_level;
			lane_s1   <= lane_index;
			length_s1 <= length_ticks;
		end
	end

	// arithmetic shift gives floor of product / 8192
	assign floor_g  = prod_s1[cvwg_pkg::PROD_W-1:cvwg_pkg::Q_SHIFT];
	assign live_raw = SUM_W'(floor_g) + SUM_W'(offset_q);

	always_comb begin
		if (live_raw < 0) begin
			live = '0;
		end else if (live_raw > cvwg_pkg::FULL_SCALE) begin
			live = cvwg_pkg::VAL_W'(cvwg_pkg::FULL_SCALE);
		end else begin
			live = live_raw[cvwg_pkg::VAL_W-1:0];
		end
	end

	// each side tests only its own threshold, even when the levels overlap
	assign clk_rise = !schmitt_q && (clk_s1 >= clk_high_q);
	assign clk_fall = schmitt_q && (clk_s1 <= clk_low_q);

	always_comb begin
		if (!clocked_q) begin
			val = live;
		end else if (clk_rise) begin
			val = live;
		end else begin
			val = held_q;
		end
	end

	assign scaled = WIN_W'(val) * WIN_W'(LANES);

	// strictly inside: a value on a boundary lights no window
	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			win_s1[i] = (scaled > WIN_W'(i * cvwg_pkg::FULL_SCALE)) &&
				(scaled < WIN_W'((i + 1) * cvwg_pkg::FULL_SCALE));
		end
	end

	assign ctl_s1.valid = v_s1;
	assign ctl_s1.wr    = op_s1;
	assign ctl_s1.lane  = lane_s1;
	assign len_s1       = length_s1;

endmodule

// ===== sv/cvwg_lanes.sv =====
module cvwg_lanes #(
	parameter int LANES       = cvwg_pkg::LANES_DEF,
	parameter int LENGTH_BITS = cvwg_pkg::LENGTH_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s1_go,
	input  cvwg_pkg::s2_ctl_t              ctl_s1,
	input  logic [LENGTH_BITS-1:0]         len_s1,
	input  logic [LANES-1:0]               win_s1,
	output logic                           s2_free,
	input  logic [LANES*LENGTH_BITS-1:0]   rem_rd,
	input  logic [LANES*LENGTH_BITS-1:0]   len_rd,
	output logic                           rem_we,
	output logic [LANES*LENGTH_BITS-1:0]   rem_wd,
	output logic [LANES-1:0]               len_we,
	output logic [LENGTH_BITS-1:0]         len_wd,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [cvwg_pkg::MASK_W-1:0]    pulse_mask,
	output logic [cvwg_pkg::MASK_W-1:0]    window_mask
);

	cvwg_pkg::s2_ctl_t        ctl_s2;
	logic [LENGTH_BITS-1:0]   len_s2;
	logic [LANES-1:0]         win_s2;
	logic [LANES-1:0]         win_prev_q;
	logic                     out_valid_q;
	logic [cvwg_pkg::MASK_W-1:0] pulse_q;
	logic [cvwg_pkg::MASK_W-1:0] window_q;

	logic                     out_free;
	logic                     s2_go;
	logic                     tick;
	logic [LANES-1:0]         pulse;
	logic [cvwg_pkg::MASK_W-1:0] pulse_pack;
	logic [cvwg_pkg::MASK_W-1:0] window_pack;

	assign out_free = !out_valid_q || out_ready;
	// a length write leaves no beat, so it never waits on the output
	assign s2_go    = ctl_s2.valid && (ctl_s2.wr || out_free);
	assign s2_free  = !ctl_s2.valid || s2_go;
	assign tick     = s2_go && (ctl_s2.wr == cvwg_pkg::OP_TICK);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2      <= '0;
			win_prev_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (s1_go) begin
				ctl_s2 <= ctl_s1;
			end else if (s2_go) begin
				ctl_s2.valid <= 1'b0;
			end
			if (tick) begin
				win_prev_q  <= win_s2;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go) begin
			len_s2 <= len_s1;
			win_s2 <= win_s1;
		end
		if (tick) begin
			pulse_q  <= pulse_pack;
			window_q <= window_pack;
		end
	end

	// per lane: retrigger keeps the longer count, high while count > 0, then count down
	always_comb begin
		logic [LENGTH_BITS-1:0] rem;
		logic [LENGTH_BITS-1:0] tab;
		logic [LENGTH_BITS-1:0] nxt;
		for (int i = 0; i < LANES; i++) begin
			rem = rem_rd[i*LENGTH_BITS +: LENGTH_BITS];
			tab = len_rd[i*LENGTH_BITS +: LENGTH_BITS];
			if (win_s2[i] && !win_prev_q[i] && (tab > rem)) begin
				nxt = tab;
			end else begin
				nxt = rem;
			end
			pulse[i] = (nxt != '0);
			rem_wd[i*LENGTH_BITS +: LENGTH_BITS] = nxt - LENGTH_BITS'(pulse[i]);
			len_we[i] = s2_go && (ctl_s2.wr == cvwg_pkg::OP_WRITE) && (int'(ctl_s2.lane) == i);
		end
	end

	assign rem_we = tick;
	assign len_wd = len_s2;

	// lanes above the mask width are dropped, missing lanes read as zero
	for (genvar g = 0; g < cvwg_pkg::MASK_W; g++) begin : g_pack
		if (g < LANES) begin : g_lane
			assign pulse_pack[g]  = pulse[g];
			assign window_pack[g] = win_s2[g];
		end else begin : g_none
			assign pulse_pack[g]  = 1'b0;
			assign window_pack[g] = 1'b0;
		end
	end

	assign out_valid   = out_valid_q;
	assign pulse_mask  = pulse_q;
	assign window_mask = window_q;

endmodule

// ===== sv/cv_window_gate_demux.sv =====
// Pipeline: a tick beat passes scale/Schmitt/windows, lane read-modify-write and the
// output register; a stalled output holds it back.
// Throughput: one beat per cycle while the output is not stalled, set by the lane state update with forwarding.
// Reset (arst_n, async, active low): config to defaults, pipeline empty, Schmitt low,
// held value and pulse counts zero; length table reads 960 per lane until written.
module cv_window_gate_demux #(
	parameter int LANES       = cvwg_pkg::LANES_DEF,
	parameter int LENGTH_BITS = cvwg_pkg::LENGTH_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [cvwg_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [cvwg_pkg::CFG_DATA_W-1:0]   cfg_data,
	cvwg_in_if.sink                           item,
	cvwg_out_if.source                        result
);

	logic                          s1_go;
	logic                          s2_free;
	cvwg_pkg::s2_ctl_t             ctl_s1;
	logic [LENGTH_BITS-1:0]        len_s1;
	logic [LANES-1:0]              win_s1;
	logic [LANES*LENGTH_BITS-1:0]  rem_rd;
	logic [LANES*LENGTH_BITS-1:0]  len_rd;
	logic                          rem_we;
	logic [LANES*LENGTH_BITS-1:0]  rem_wd;
	logic [LANES-1:0]              len_we;
	logic [LENGTH_BITS-1:0]        len_wd;

	cvwg_front #(
		.LANES       (LANES),
		.LENGTH_BITS (LENGTH_BITS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (item.valid),
		.in_ready     (item.ready),
		.opcode       (item.opcode),
		.cv_sample    (item.cv_sample),
		.clock_level  (item.clock_level),
		.lane_index   (item.lane_index),
		.length_ticks (item.length_ticks),
		.s2_free      (s2_free),
		.s1_go        (s1_go),
		.ctl_s1       (ctl_s1),
		.len_s1       (len_s1),
		.win_s1       (win_s1)
	);

	cvwg_lane_mem #(
		.LANES       (LANES),
		.LENGTH_BITS (LENGTH_BITS)
	) u_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.rem_we (rem_we),
		.rem_wd (rem_wd),
		.len_we (len_we),
		.len_wd (len_wd),
		.rem_rd (rem_rd),
		.len_rd (len_rd)
	);

	cvwg_lanes #(
		.LANES       (LANES),
		.LENGTH_BITS (LENGTH_BITS)
	) u_lanes (
		.clk         (clk),
		.arst_n      (arst_n),
		.s1_go       (s1_go),
		.ctl_s1      (ctl_s1),
		.len_s1      (len_s1),
		.win_s1      (win_s1),
		.s2_free     (s2_free),
		.rem_rd      (rem_rd),
		.len_rd      (len_rd),
		.rem_we      (rem_we),
		.rem_wd      (rem_wd),
		.len_we      (len_we),
		.len_wd      (len_wd),
		.out_valid   (result.valid),
		.out_ready   (result.ready),
		.pulse_mask  (result.pulse_mask),
		.window_mask (result.window_mask)
	);

endmodule

// ===== tb/sv/cvwg_mask_checker.sv =====
module cvwg_mask_checker
	import cvwg_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	cvwg_in_if                    item,
	cvwg_out_if                   result,
	output int                    failures,
	output int                    outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LANES = LANES_DEF;
	localparam int LEN_W = LENGTH_BITS_DEF;

	typedef struct packed {
		logic [MASK_W-1:0] pulses;
		logic [MASK_W-1:0] windows;
	} masks_t;

	logic signed [GAIN_W-1:0] gain;
	logic signed [OFS_W-1:0]  offset;
	logic                     clocked;
	logic signed [LVL_W-1:0]  level_high;
	logic signed [LVL_W-1:0]  level_low;
	logic [VAL_W-1:0]         held_value;
	logic                     schmitt_high;
	logic [LANES-1:0]         windows_prev;
	logic [LEN_W-1:0]         lane_left [LANES];
	logic [LEN_W-1:0]         lane_length [LANES];
	masks_t                   expected_masks [$];
	int                       mismatches;

	task automatic report(input string msg);
		mismatches++;
		$display("%0t ns: %s", $time, msg);
	endtask

	// advances the gate state by one sample tick and returns the masks it shows
	function automatic masks_t gate_tick(logic signed [CV_W-1:0] cv,
		logic signed [LVL_W-1:0] lvl);
		longint product;
		longint live;
		int     scaled;
		logic   rise;
		masks_t m;
		product = longint'(cv) * longint'(gain);
		live = (product >>> Q_SHIFT) + longint'(offset);
		if (live < 0)
			live = 0;
		if (live > FULL_SCALE)
			live = FULL_SCALE;
		rise = 1'b0;
		// hysteresis: only the threshold for leaving the current state is tested
		if (schmitt_high) begin
			if (lvl <= level_low)
				schmitt_high = 1'b0;
		end else if (lvl >= level_high) begin
			schmitt_high = 1'b1;
			rise = 1'b1;
		end
		if (rise)
			held_value = live[VAL_W-1:0];
		scaled = LANES * (clocked ? int'(held_value) : int'(live));
		m = '0;
		for (int i = 0; i < LANES; i++) begin
			if (scaled > i * FULL_SCALE && scaled < (i + 1) * FULL_SCALE) begin
				m.windows[i] = 1'b1;
				if (!windows_prev[i] && lane_length[i] > lane_left[i])
					lane_left[i] = lane_length[i];
			end
			if (lane_left[i] != '0) begin
				m.pulses[i] = 1'b1;
				lane_left[i] = lane_left[i] - 1'b1;
			end
		end
		windows_prev = m.windows;
		return m;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		masks_t want;
		if (!arst_n) begin
			gain = GAIN_RST;
			offset = OFFSET_RST;
			clocked = 1'b0;
			level_high = CLK_HIGH_RST;
			level_low = CLK_LOW_RST;
			held_value = '0;
			schmitt_high = 1'b0;
			windows_prev = '0;
			for (int i = 0; i < LANES; i++) begin
				lane_left[i] = '0;
				lane_length[i] = LEN_W'(DEFAULT_LENGTH);
			end
			expected_masks.delete();
			mismatches = 0;
		end else begin
			if (result.valid && result.ready) begin
				if (expected_masks.size() == 0) begin
					report($sformatf("result beat with nothing expected: pulse_mask %02h window_mask %02h",
						result.pulse_mask, result.window_mask));
				end else begin
					want = expected_masks.pop_front();
					if (result.pulse_mask !== want.pulses)
						report($sformatf("pulse_mask %02h, expected %02h",
							result.pulse_mask, want.pulses));
					if (result.window_mask !== want.windows)
						report($sformatf("window_mask %02h, expected %02h",
							result.window_mask, want.windows));
				end
			end
			if (item.valid && item.ready) begin
				if (item.opcode == OP_WRITE) begin
					if (int'(item.lane_index) < LANES)
						lane_length[item.lane_index] = item.length_ticks;
				end else begin
					expected_masks.push_back(gate_tick(item.cv_sample, item.clock_level));
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					CFG_GAIN:     gain = cfg_data[GAIN_W-1:0];
					CFG_OFFSET:   offset = cfg_data[OFS_W-1:0];
					CFG_CLOCKED:  clocked = cfg_data[0];
					CFG_CLK_HIGH: level_high = cfg_data[LVL_W-1:0];
					CFG_CLK_LOW:  level_low = cfg_data[LVL_W-1:0];
					default: ;
				endcase
			end
		end
		failures <= mismatches;
		outstanding <= expected_masks.size();
	end

endmodule

// ===== tb/sv/tb_cv_window_gate_demux.sv =====
module tb_cv_window_gate_demux;
	timeunit 1ns;
	timeprecision 1ps;
	import cvwg_pkg::*;

	localparam int IDLE_LIMIT   = 2000;
	localparam int PHASE_ITEMS  = 208;
	localparam int DRAIN_CYCLES = 6;
	localparam int WIN_WIDTH    = FULL_SCALE / LANES_DEF;

	typedef struct {
		logic op;
		int   cv;
		int   lvl;
		int   lane;
		int   len;
	} stim_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	int                    failures;
	int                    outstanding;
	int                    cur_gain;
	int                    cur_offset;
	int                    cur_high;
	int                    cur_low;
	int                    burst_left;
	int                    idle_cycles;
	int unsigned           rx_mode;
	int unsigned           rx_left;
	int unsigned           rx_count;
	bit                    long_lengths;

	cvwg_in_if #(.LENGTH_BITS(LENGTH_BITS_DEF)) item_ch ();
	cvwg_out_if result_ch ();

	cv_window_gate_demux DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.item      (item_ch),
		.result    (result_ch)
	);

	cvwg_mask_checker u_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.item        (item_ch),
		.result      (result_ch),
		.failures    (failures),
		.outstanding (outstanding)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// receiver: switches between always ready, coin flip, mostly stalled and a fixed duty pattern
	always @(posedge clk) begin
		if (rx_left == 0) begin
			rx_mode <= $urandom_range(3);
			rx_left <= $urandom_range(300, 30);
		end else begin
			rx_left <= rx_left - 1;
		end
		rx_count <= rx_count + 1;
		case (rx_mode)
			0: result_ch.ready <= 1'b1;
			1: result_ch.ready <= 1'($urandom_range(1));
			2: result_ch.ready <= ($urandom_range(3) == 0);
			default: result_ch.ready <= (rx_count % 16) < 11;
		endcase
	end

	always @(posedge clk) begin
		if (!arst_n || cfg_we || (item_ch.valid && item_ch.ready) ||
			(result_ch.valid && result_ch.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("tb_cv_window_gate_demux failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic send(input stim_t s);
		int gap;
		if (burst_left == 0) begin
			if ($urandom_range(4) == 0)
				burst_left = $urandom_range(150, 40);
			else
				burst_left = $urandom_range(12, 1);
			gap = $urandom_range(10);
			if (gap > 0) begin
				item_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		item_ch.valid <= 1'b1;
		item_ch.opcode <= s.op;
		item_ch.cv_sample <= CV_W'(s.cv);
		item_ch.clock_level <= LVL_W'(s.lvl);
		item_ch.lane_index <= LANE_IDX_W'(s.lane);
		item_ch.length_ticks <= LENGTH_BITS_DEF'(s.len);
		do @(posedge clk); while (item_ch.ready !== 1'b1);
	endtask

	// hold off until every result beat is back, then let trailing write beats clear the pipe
	task automatic settle();
		item_ch.valid <= 1'b0;
		burst_left = 0;
		do @(posedge clk); while (outstanding != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic configure(input int g, input int o, input int c, input int h, input int l);
		cur_gain = g;
		cur_offset = o;
		cur_high = h;
		cur_low = l;
		cfg_we <= 1'b1;
		cfg_index <= CFG_GAIN;
		cfg_data <= CFG_DATA_W'(g);
		@(posedge clk);
		cfg_index <= CFG_OFFSET;
		cfg_data <= CFG_DATA_W'(o);
		@(posedge clk);
		cfg_index <= CFG_CLOCKED;
		cfg_data <= CFG_DATA_W'(c);
		@(posedge clk);
		cfg_index <= CFG_CLK_HIGH;
		cfg_data <= CFG_DATA_W'(h);
		@(posedge clk);
		cfg_index <= CFG_CLK_LOW;
		cfg_data <= CFG_DATA_W'(l);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic stim_t tick_of(input int cv, input int lvl);
		stim_t s;
		s.op = OP_TICK;
		s.cv = cv;
		s.lvl = lvl;
		s.lane = $urandom_range(7);
		s.len = $urandom_range(131071);
		return s;
	endfunction

	function automatic stim_t write_of(input int lane, input int len);
		stim_t s;
		s.op = OP_WRITE;
		s.cv = $urandom_range(65535);
		s.lvl = $urandom_range(65535);
		s.lane = lane;
		s.len = len;
		return s;
	endfunction

	// cv that lands near scaled value t under the current gain and offset
	function automatic int cv_toward(input int t);
		longint c;
		if (cur_gain == 0)
			return int'($urandom_range(65535)) - 32768;
		c = (longint'(t - cur_offset) * 64'sd8192) / cur_gain + int'($urandom_range(1));
		if (c > 32767)
			c = 32767;
		if (c < -32768)
			c = -32768;
		return int'(c);
	endfunction

	function automatic int random_cv();
		case ($urandom_range(7))
			0, 1, 2, 3: return cv_toward(int'($urandom_range(FULL_SCALE)));
			4, 5: return cv_toward(WIN_WIDTH * int'($urandom_range(LANES_DEF)) +
				int'($urandom_range(4)) - 2);
			6: return cv_toward(int'($urandom_range(1)) ? -int'($urandom_range(3000)) :
				FULL_SCALE + int'($urandom_range(3000)));
			default: return int'($urandom_range(65535)) - 32768;
		endcase
	endfunction

	function automatic int hi_side();
		int v;
		v = cur_high + int'($urandom_range(1500));
		return v > 32767 ? 32767 : v;
	endfunction

	function automatic int lo_side();
		int v;
		v = cur_low - int'($urandom_range(1500));
		return v < -32768 ? -32768 : v;
	endfunction

	function automatic int random_level();
		case ($urandom_range(7))
			0, 1, 2: return hi_side();
			3, 4, 5: return lo_side();
			6: return int'($urandom_range(1)) ? cur_high : cur_low;
			default: return int'($urandom_range(65535)) - 32768;
		endcase
	endfunction

	function automatic int random_length();
		int r;
		r = $urandom_range(19);
		if (long_lengths && r == 0)
			return $urandom_range(131071);
		if (r < 15)
			return $urandom_range(40);
		return $urandom_range(400, 41);
	endfunction

	task automatic run_random(input int count);
		int left;
		int n;
		int t;
		int stride;
		left = count;
		while (left > 0) begin
			case ($urandom_range(9))
				0: begin
					send(write_of($urandom_range(7), random_length()));
					left--;
				end
				1, 2, 3: begin
					// sweep through neighboring windows
					n = $urandom_range(16, 3);
					t = $urandom_range(FULL_SCALE);
					stride = int'($urandom_range(1400)) - 700;
					repeat (n) begin
						send(tick_of(cv_toward(t), random_level()));
						t += stride;
					end
					left -= n;
				end
				4, 5: begin
					// clock flips every beat so the held value keeps getting resampled
					n = $urandom_range(12, 2);
					for (int k = 0; k < n; k++)
						send(tick_of(random_cv(), k[0] ? lo_side() : hi_side()));
					left -= n;
				end
				default: begin
					send(tick_of(random_cv(), random_level()));
					left--;
				end
			endcase
		end
	endtask

	initial begin
		int g;
		int o;
		int h;
		int l;
		int swap;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= CFG_GAIN;
		cfg_data <= '0;
		item_ch.valid <= 1'b0;
		item_ch.opcode <= OP_TICK;
		item_ch.cv_sample <= '0;
		item_ch.clock_level <= '0;
		item_ch.lane_index <= '0;
		item_ch.length_ticks <= '0;
		cur_gain = GAIN_RST;
		cur_offset = OFFSET_RST;
		cur_high = CLK_HIGH_RST;
		cur_low = CLK_LOW_RST;
		burst_left = 0;
		long_lengths = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send(write_of(0, 1));
		send(write_of(1, 0));
		send(write_of(2, 131071));
		send(write_of(2, 5));
		send(write_of(7, 2));
		send(tick_of(0, -32768));       // 0 V is a boundary
		send(tick_of(640, 32767));      // one-tick pulse on lane 0
		send(tick_of(1280, 0));         // boundary between windows 0 and 1
		send(tick_of(1920, 1023));      // zero length: window but no pulse
		send(tick_of(3200, 1024));
		send(tick_of(10240, 1));        // 10 V is a boundary too
		send(tick_of(32767, -1));
		send(tick_of(-32768, 0));
		send(tick_of(3201, 2000));      // retrigger while still counting down
		send(write_of(2, 2));
		send(tick_of(3300, 0));
		send(tick_of(8960, 0));
		send(tick_of(3000, 0));
		send(tick_of(4480, 0));         // lane 3 still has the default length
		send(tick_of(10239, 0));
		send(tick_of(1, 0));
		settle();

		// thresholds swapped: high below low
		configure(8192, 0, 1, -100, 100);
		send(tick_of(5000, -100));
		send(tick_of(7000, 50));
		send(tick_of(7100, 100));
		send(tick_of(2000, 101));
		send(tick_of(9000, -101));
		send(tick_of(600, -100));

		for (int p = 0; p < 9; p++) begin
			settle();
			case (p)
				0: configure(8192, 0, 0, 1024, 0);
				1: configure(16384, -10240, 1, 2048, -2048);
				2: configure(-16384, 10240, 0, 32767, -32768);
				3: configure(0, 5000, 1, -32768, 32767);
				4: configure(-8192, 10240, 1, 500, 400);
				default: begin
					g = int'($urandom_range(32768)) - 16384;
					o = int'($urandom_range(20480)) - 10240;
					h = int'($urandom_range(65535)) - 32768;
					l = int'($urandom_range(65535)) - 32768;
					if ($urandom_range(3) != 0 && l > h) begin
						swap = l;
						l = h;
						h = swap;
					end
					configure(g, o, $urandom_range(1), h, l);
				end
			endcase
			long_lengths = (p == 8);
			run_random(PHASE_ITEMS);
		end
		settle();

		if (failures == 0)
			$display("tb_cv_window_gate_demux passed");
		else
			$display("tb_cv_window_gate_demux failed");
		$finish;
	end

endmodule
